// ----- rtl/lkit_pkg.sv -----
package lkit_pkg;

  // table geometry
  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned KEY_W   = 4 * WORD_W;
  localparam int unsigned STAMP_W = 64;

  typedef enum logic [1:0] {
    CMD_LOOKUP   = 2'd0,
    CMD_REMEMBER = 2'd1,
    CMD_FORGET   = 2'd2
  } cmd_e;

  // one slot as read from the slot memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   group;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

  // write port of the slot memory
  typedef struct packed {
    logic               en;
    logic               en_entry;
    logic [IDX_W-1:0]   addr;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   group;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

  // compare unit results
  typedef struct packed {
    logic key_eq;
    logic grp_eq;
    logic lru_less;
  } cmp_t;

endpackage

// ----- rtl/lkit_if.sv -----
interface lkit_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic [lkit_pkg::WORD_W-1:0] key_w0;
  logic [lkit_pkg::WORD_W-1:0] key_w1;
  logic [lkit_pkg::WORD_W-1:0] key_w2;
  logic [lkit_pkg::WORD_W-1:0] key_w3;
  logic [lkit_pkg::WORD_W-1:0] group_w0;
  logic [lkit_pkg::WORD_W-1:0] group_w1;
  logic [lkit_pkg::WORD_W-1:0] group_w2;
  logic [lkit_pkg::WORD_W-1:0] group_w3;

  modport source (
    output valid, cmd, key_w0, key_w1, key_w2, key_w3,
    output group_w0, group_w1, group_w2, group_w3,
    input  ready
  );
  modport sink (
    input  valid, cmd, key_w0, key_w1, key_w2, key_w3,
    input  group_w0, group_w1, group_w2, group_w3,
    output ready
  );
endinterface

interface lkit_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// ----- rtl/lkit_slot_store.sv -----
module lkit_slot_store (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [lkit_pkg::IDX_W-1:0]  rd_addr_i,
  input  lkit_pkg::wr_t               wr_i,
  output lkit_pkg::slot_t             rd_data_o
);

  logic [lkit_pkg::KEY_W-1:0]   key_mem   [lkit_pkg::ENTRIES];
  logic [lkit_pkg::KEY_W-1:0]   grp_mem   [lkit_pkg::ENTRIES];
  logic [lkit_pkg::STAMP_W-1:0] stamp_mem [lkit_pkg::ENTRIES];
  lkit_pkg::slot_t              rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      stamp_mem[wr_i.addr] <= wr_i.stamp;
    end
    if (wr_i.en_entry) begin
      key_mem[wr_i.addr] <= wr_i.key;
      grp_mem[wr_i.addr] <= wr_i.group;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.key   <= key_mem[rd_addr_i];
      rd_q.group <= grp_mem[rd_addr_i];
      rd_q.stamp <= stamp_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- rtl/lkit_cmp_unit.sv -----
module lkit_cmp_unit (
  input  lkit_pkg::slot_t               slot_i,
  input  logic [lkit_pkg::KEY_W-1:0]    key_i,
  input  logic [lkit_pkg::KEY_W-1:0]    group_i,
  input  logic [lkit_pkg::STAMP_W-1:0]  best_stamp_i,
  input  logic [lkit_pkg::KEY_W-1:0]    best_key_i,
  output lkit_pkg::cmp_t                cmp_o
);

  logic stamp_lt;
  logic stamp_eq;
  logic key_lt;

  assign stamp_lt = slot_i.stamp < best_stamp_i;
  assign stamp_eq = slot_i.stamp == best_stamp_i;
  // unsigned 256-bit compare, word 0 most significant
  assign key_lt   = slot_i.key < best_key_i;

  assign cmp_o.key_eq   = slot_i.key == key_i;
  assign cmp_o.grp_eq   = slot_i.group == group_i;
  // older stamp wins, equal stamps go to the lower key
  assign cmp_o.lru_less = stamp_lt || (stamp_eq && key_lt);

endmodule

// ----- rtl/lru_key_index_table.sv -----
// Fully associative table of ENTRIES slots (64 here) with least-recently-used
// replacement. A request carries a command (lookup, remember, forget), a 256-bit
// key and a 256-bit group key; each request returns exactly one response whose
// hit bit is set only for a lookup that found the key. The block handles one
// request at a time: it takes a request when idle, then scans the slot memory
// from slot 0 upward at one slot per cycle, since the memory has one registered
// read port and a single compare unit checks one slot per cycle. A lookup hit
// or a remember that meets its key or an empty slot stops the scan early, and an
// unused command code skips the scan and goes straight to the response. The
// response sits in an output register, so a new request is taken while the
// previous response still waits. Occupied flags are flip-flops cleared by
// reset; keys, group keys and stamps live in memory and are only used for
// occupied slots, so no clearing pass is needed.
module lru_key_index_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  lkit_req_if.sink     req_i,
  lkit_rsp_if.source   rsp_o
);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam logic [lkit_pkg::IDX_W-1:0] LAST_IDX = lkit_pkg::IDX_W'(lkit_pkg::ENTRIES - 1);
  localparam logic [lkit_pkg::CNT_W-1:0] CNT_END  = lkit_pkg::CNT_W'(lkit_pkg::ENTRIES);

  logic [1:0]                   state_q, state_d;
  lkit_pkg::cmd_e               cmd_q, cmd_d;
  logic [lkit_pkg::KEY_W-1:0]   key_q, key_d;
  logic [lkit_pkg::KEY_W-1:0]   grp_q, grp_d;

  // scan pointers: issue side feeds the memory, eval side sees its data
  logic [lkit_pkg::CNT_W-1:0]   iss_q, iss_d;
  logic [lkit_pkg::IDX_W-1:0]   ev_q, ev_d;
  logic                         ev_vld_q, ev_vld_d;

  // least-recently-used candidate so far
  logic                         have_best_q, have_best_d;
  logic [lkit_pkg::IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [lkit_pkg::STAMP_W-1:0] best_stamp_q, best_stamp_d;
  logic [lkit_pkg::KEY_W-1:0]   best_key_q, best_key_d;

  logic [lkit_pkg::IDX_W-1:0]   sel_q, sel_d;
  logic                         hit_q, hit_d;
  logic [lkit_pkg::ENTRIES-1:0] valid_q, valid_d;
  logic [lkit_pkg::STAMP_W-1:0] use_ctr_q, use_ctr_d;

  // response register
  logic                         out_vld_q, out_vld_d;
  logic                         out_hit_q, out_hit_d;
  logic                         load_res;

  logic                         rd_en;
  logic [lkit_pkg::IDX_W-1:0]   rd_addr;
  lkit_pkg::wr_t                wr;
  lkit_pkg::slot_t              rd_data;
  lkit_pkg::cmp_t               cmp;
  logic                         slot_vld;
  logic                         is_last;

  lkit_slot_store u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_data_o (rd_data)
  );

  lkit_cmp_unit u_cmp (
    .slot_i       (rd_data),
    .key_i        (key_q),
    .group_i      (grp_q),
    .best_stamp_i (best_stamp_q),
    .best_key_i   (best_key_q),
    .cmp_o        (cmp)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.hit   = out_hit_q;

  assign slot_vld = valid_q[ev_q];
  assign is_last  = (ev_q == LAST_IDX);
  assign rd_addr  = iss_q[lkit_pkg::IDX_W-1:0];

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    grp_d        = grp_q;
    iss_d        = iss_q;
    ev_d         = ev_q;
    ev_vld_d     = ev_vld_q;
    have_best_d  = have_best_q;
    best_idx_d   = best_idx_q;
    best_stamp_d = best_stamp_q;
    best_key_d   = best_key_q;
    sel_d        = sel_q;
    hit_d        = hit_q;
    valid_d      = valid_q;
    use_ctr_d    = use_ctr_q;
    load_res     = 1'b0;
    rd_en        = 1'b0;

    wr           = '0;
    wr.addr      = sel_q;
    wr.key       = key_q;
    wr.group     = grp_q;
    wr.stamp     = use_ctr_q + lkit_pkg::STAMP_W'(1);

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          cmd_d       = lkit_pkg::cmd_e'(req_i.cmd);
          key_d       = {req_i.key_w0, req_i.key_w1, req_i.key_w2, req_i.key_w3};
          grp_d       = {req_i.group_w0, req_i.group_w1, req_i.group_w2, req_i.group_w3};
          iss_d       = '0;
          ev_vld_d    = 1'b0;
          have_best_d = 1'b0;
          hit_d       = 1'b0;
          case (lkit_pkg::cmd_e'(req_i.cmd))
            lkit_pkg::CMD_LOOKUP,
            lkit_pkg::CMD_REMEMBER,
            lkit_pkg::CMD_FORGET: state_d = ST_SCAN;
            // unused code: no table change, plain miss
            default:              state_d = ST_FIN;
          endcase
        end
      end

      ST_SCAN: begin
        // issue the next slot read while the previous one is checked
        rd_en = (iss_q < CNT_END);
        if (rd_en) begin
          iss_d = iss_q + lkit_pkg::CNT_W'(1);
        end
        ev_d     = rd_addr;
        ev_vld_d = rd_en;

        if (ev_vld_q) begin
          case (cmd_q)
            lkit_pkg::CMD_LOOKUP: begin
              if (slot_vld && cmp.key_eq) begin
                // first occupied match takes a fresh stamp
                sel_d   = ev_q;
                hit_d   = 1'b1;
                state_d = ST_WRITE;
              end else if (is_last) begin
                state_d = ST_FIN;
              end
            end
            lkit_pkg::CMD_REMEMBER: begin
              if (!slot_vld || cmp.key_eq) begin
                // matching or empty slot ends the scan
                sel_d   = ev_q;
                state_d = ST_WRITE;
              end else begin
                if (!have_best_q || cmp.lru_less) begin
                  have_best_d  = 1'b1;
                  best_idx_d   = ev_q;
                  best_stamp_d = rd_data.stamp;
                  best_key_d   = rd_data.key;
                end
                if (is_last) begin
                  // table full: evict the oldest slot
                  sel_d   = (!have_best_q || cmp.lru_less) ? ev_q : best_idx_q;
                  state_d = ST_WRITE;
                end
              end
            end
            lkit_pkg::CMD_FORGET: begin
              if (slot_vld && cmp.grp_eq) begin
                valid_d[ev_q] = 1'b0;
              end
              if (is_last) begin
                state_d = ST_FIN;
              end
            end
            default: state_d = ST_FIN;
          endcase
        end

        // drop the read still in flight once the scan ends
        if (state_d != ST_SCAN) begin
          ev_vld_d = 1'b0;
        end
      end

      ST_WRITE: begin
        // stamp always, key and group only when remembering
        wr.en       = 1'b1;
        wr.en_entry = (cmd_q == lkit_pkg::CMD_REMEMBER);
        if (wr.en_entry) begin
          valid_d[sel_q] = 1'b1;
        end
        use_ctr_d = use_ctr_q + lkit_pkg::STAMP_W'(1);
        state_d   = ST_FIN;
      end

      ST_FIN: begin
        // hand over once the response register is free
        if (!out_vld_q || rsp_o.ready) begin
          load_res = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_hit_d = out_hit_q;
    if (load_res) begin
      out_vld_d = 1'b1;
      out_hit_d = hit_q;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iss_q       <= '0;
      ev_vld_q    <= 1'b0;
      have_best_q <= 1'b0;
      valid_q     <= '0;
      use_ctr_q   <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      ev_vld_q    <= ev_vld_d;
      have_best_q <= have_best_d;
      valid_q     <= valid_d;
      use_ctr_q   <= use_ctr_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    grp_q        <= grp_d;
    ev_q         <= ev_d;
    best_idx_q   <= best_idx_d;
    best_stamp_q <= best_stamp_d;
    best_key_q   <= best_key_d;
    sel_q        <= sel_d;
    hit_q        <= hit_d;
    out_hit_q    <= out_hit_d;
  end

  // a hit is only ever reported for a lookup
  a_hit_lookup_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_res && hit_q) |-> (cmd_q == lkit_pkg::CMD_LOOKUP))
    else $error("hit reported for a non-lookup request");

  // the use counter moves only after a slot write
  a_ctr_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (use_ctr_q != $past(use_ctr_q)) |-> ($past(state_q) == ST_WRITE))
    else $error("use counter changed outside a slot write");

  // a remembered slot is occupied right after its write
  a_remember_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en_entry |=> valid_q[$past(wr.addr)])
    else $error("remembered slot not marked occupied");

  // an accepted request always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

endmodule
